// ===== sv/iaap_pkg.sv =====
// shared types and constants of the iso14443a anticollision poller
package iaap_pkg;

	// default sizes
	localparam int MAX_UID_BYTES_DEF  = 10;
	localparam int CASCADE_LEVELS_DEF = 3;

	// fixed field widths
	localparam int UID_CNT_W     = 4;
	localparam int UID_VIEW_BYTES = 10;
	localparam int FRAME_BYTES   = 5;

	// protocol constants
	localparam logic [7:0] SEL_CL1     = 8'h93;
	localparam logic [7:0] NVB_ANTICOL = 8'h20;
	localparam logic [7:0] NVB_SELECT  = 8'h70;
	localparam logic [7:0] CASCADE_TAG = 8'h88;

	// input item kinds
	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_REPLY = 2'd1,
		FN_FAIL  = 2'd2,
		FN_TICK  = 2'd3
	} func_t;

	// result item kinds
	typedef enum logic [2:0] {
		ACT_WUPA    = 3'd0,
		ACT_ANTICOL = 3'd1,
		ACT_SELECT  = 3'd2,
		ACT_FOUND   = 3'd3,
		ACT_TIMEOUT = 3'd4
	} action_t;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATQA    = 3'd1,
		PH_ANTICOL = 3'd2,
		PH_SAK     = 3'd3,
		PH_WAIT    = 3'd4
	} phase_t;

	// control from the sequencer to the uid store
	typedef struct packed {
		logic clear;
		logic append;
		logic tag;
	} uid_ctl_t;

endpackage

// ===== sv/iaap_uid_store.sv =====
// uid byte store with append, saturating count and packed uid view
module iaap_uid_store
	import iaap_pkg::*;
#(
	parameter int MAX_UID_BYTES = MAX_UID_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  uid_ctl_t                    ctl,
	input  logic [FRAME_BYTES-1:0][7:0] src,
	output logic [63:0]                 uid_low,
	output logic [15:0]                 uid_high,
	output logic [UID_CNT_W-1:0]        uid_length
);

	logic [7:0]           bytes_q [MAX_UID_BYTES];
	logic [7:0]           bytes_d [MAX_UID_BYTES];
	logic [UID_CNT_W-1:0] count_q;
	logic [UID_CNT_W-1:0] count_d;
	logic [4:0]           count_ext;
	logic [4:0]           n_bytes;
	logic [4:0]           sum;
	logic [8*UID_VIEW_BYTES-1:0] view;

	assign count_ext = {1'b0, count_q};
	assign n_bytes   = ctl.tag ? 5'd3 : 5'd4;
	assign sum       = count_ext + n_bytes;

	// next count, saturating at the store depth
	always_comb begin
		count_d = count_q;
		if (ctl.clear) begin
			count_d = '0;
		end else if (ctl.append) begin
			if (sum > 5'(MAX_UID_BYTES)) begin
				count_d = UID_CNT_W'(MAX_UID_BYTES);
			end else begin
				count_d = sum[UID_CNT_W-1:0];
			end
		end
	end

	// each entry picks its byte from the held frame when it lies in the append window
	always_comb begin
		logic [4:0] off;
		logic [2:0] k;
		for (int e = 0; e < MAX_UID_BYTES; e++) begin
			off = 5'(e) - count_ext;
			k = off[2:0] + {2'b0, ctl.tag};
			bytes_d[e] = bytes_q[e];
			if (ctl.append && (5'(e) >= count_ext) && (off < n_bytes)) begin
				bytes_d[e] = src[k];
			end
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// byte registers, undefined until written
	always_ff @(posedge clk) begin
		for (int e = 0; e < MAX_UID_BYTES; e++) begin
			bytes_q[e] <= bytes_d[e];
		end
	end

	// packed view of the next contents, bytes past the count read zero
	for (genvar g = 0; g < UID_VIEW_BYTES; g++) begin : g_view
		if (g < MAX_UID_BYTES) begin : g_used
			assign view[8*g +: 8] = (UID_CNT_W'(g) < count_d) ? bytes_d[g] : 8'h00;
		end else begin : g_unused
			assign view[8*g +: 8] = 8'h00;
		end
	end

	assign uid_low    = view[63:0];
	assign uid_high   = view[79:64];
	assign uid_length = count_d;

endmodule

// ===== sv/iso14443a_anticollision_poller_core.sv =====
// iso14443a reader-side detection sequencer: wupa, anticollision and select cascade
// an accepted input item waits in the input register; any result item it yields is held in the result register
// throughput: one input item per cycle while the result register is free
// a stalled result holds the input register, which then holds the input side
// reset: asynchronous active low, phase idle, counters and held values cleared
// the uid bytes have no reset; only bytes written in the running detection are shown
module iso14443a_anticollision_poller_core
	import iaap_pkg::*;
#(
	parameter int MAX_UID_BYTES  = MAX_UID_BYTES_DEF,
	parameter int CASCADE_LEVELS = CASCADE_LEVELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rx_data[39:0], rx_count[43:40], deadline_ms[59:44], zero[63:60]
	input  logic [63:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tx_select_cmd[7:0], tx_nvb[15:8], tx_uid_bcc[55:16], tx_with_crc[56],
	// uid_low[120:57], uid_high[136:121], uid_length[140:137], card_sak[148:141],
	// card_atqa[164:149], zero[167:165]
	output logic [167:0] m_tdata,
	// action[2:0]
	output logic [2:0]   m_tuser
);

	typedef struct packed {
		func_t       func;
		logic [39:0] rx;
		logic [3:0]  cnt;
		logic [15:0] tmo;
	} item_t;

	typedef struct packed {
		action_t              action;
		logic [7:0]           sel;
		logic [7:0]           nvb;
		logic [39:0]          uid_bcc;
		logic                 crc;
		logic [63:0]          uid_low;
		logic [15:0]          uid_high;
		logic [UID_CNT_W-1:0] uid_length;
		logic [7:0]           sak;
		logic [15:0]          atqa;
	} result_t;

	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [1:0]  level_q, level_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] atqa_q, atqa_d;
	logic [39:0] held_q, held_d;
	uid_ctl_t    uid_ctl;
	logic        emit;
	action_t     act;

	logic [63:0]          st_low;
	logic [15:0]          st_high;
	logic [UID_CNT_W-1:0] st_len;

	result_t     res_d, res_q;
	logic        m_valid_q;
	logic [7:0]  bcc;
	logic [15:0] rem_dec;

	// handshake: the input register moves when the result register is free
	assign advance  = !m_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func <= func_t'(s_tuser);
			item_s1.rx   <= s_tdata[39:0];
			item_s1.cnt  <= s_tdata[43:40];
			item_s1.tmo  <= s_tdata[59:44];
		end
	end

	assign bcc = item_s1.rx[7:0] ^ item_s1.rx[15:8] ^ item_s1.rx[23:16] ^ item_s1.rx[31:24];
	assign rem_dec = (remaining_q != 16'd0) ? (remaining_q - 16'd1) : 16'd0;

	// next state and result kind
	always_comb begin
		phase_d     = phase_q;
		level_d     = level_q;
		remaining_d = remaining_q;
		atqa_d      = atqa_q;
		held_d      = held_q;
		uid_ctl     = '0;
		emit        = 1'b0;
		act         = ACT_WUPA;
		if (fire) begin
			if (item_s1.func == FN_START) begin
				remaining_d   = item_s1.tmo;
				level_d       = 2'd0;
				uid_ctl.clear = 1'b1;
				emit          = 1'b1;
				if (item_s1.tmo == 16'd0) begin
					phase_d = PH_IDLE;
					act     = ACT_TIMEOUT;
				end else begin
					phase_d = PH_ATQA;
					act     = ACT_WUPA;
				end
			end else if (phase_q == PH_IDLE) begin
				// idle ignores everything but start
			end else if (item_s1.func == FN_TICK) begin
				remaining_d = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_d = PH_IDLE;
					emit    = 1'b1;
					act     = ACT_TIMEOUT;
				end else if (phase_q == PH_WAIT) begin
					phase_d = PH_ATQA;
					emit    = 1'b1;
					act     = ACT_WUPA;
				end
			end else if (phase_q == PH_WAIT) begin
				// waiting for a tick
			end else if (item_s1.func == FN_FAIL) begin
				if (phase_q == PH_ATQA) begin
					phase_d = PH_WAIT;
				end else begin
					phase_d = PH_ATQA;
					emit    = 1'b1;
					act     = ACT_WUPA;
				end
			end else begin
				unique case (phase_q)
					PH_ATQA: begin
						if (item_s1.cnt < 4'd2) begin
							phase_d = PH_WAIT;
						end else begin
							atqa_d        = item_s1.rx[15:0];
							level_d       = 2'd0;
							uid_ctl.clear = 1'b1;
							phase_d       = PH_ANTICOL;
							emit          = 1'b1;
							act           = ACT_ANTICOL;
						end
					end
					PH_ANTICOL: begin
						emit = 1'b1;
						if ((item_s1.cnt < 4'd5) || (bcc != item_s1.rx[39:32])) begin
							phase_d = PH_ATQA;
							act     = ACT_WUPA;
						end else begin
							held_d  = item_s1.rx;
							phase_d = PH_SAK;
							act     = ACT_SELECT;
						end
					end
					PH_SAK: begin
						emit = 1'b1;
						if (item_s1.cnt < 4'd1) begin
							phase_d = PH_ATQA;
							act     = ACT_WUPA;
						end else if (held_q[7:0] == CASCADE_TAG) begin
							// cascade tag at the last level is invalid
							if (({1'b0, level_q} + 3'd1) >= 3'(CASCADE_LEVELS)) begin
								phase_d = PH_ATQA;
								act     = ACT_WUPA;
							end else begin
								uid_ctl.append = 1'b1;
								uid_ctl.tag    = 1'b1;
								level_d        = level_q + 2'd1;
								phase_d        = PH_ANTICOL;
								act            = ACT_ANTICOL;
							end
						end else begin
							uid_ctl.append = 1'b1;
							phase_d        = PH_IDLE;
							act            = ACT_FOUND;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						emit    = 1'b0;
					end
				endcase
			end
		end
	end

	// result payload for the chosen kind
	always_comb begin
		res_d        = '0;
		res_d.action = act;
		unique case (act)
			ACT_ANTICOL: begin
				res_d.sel = SEL_CL1 + {5'b0, level_d, 1'b0};
				res_d.nvb = NVB_ANTICOL;
			end
			ACT_SELECT: begin
				res_d.sel     = SEL_CL1 + {5'b0, level_d, 1'b0};
				res_d.nvb     = NVB_SELECT;
				res_d.uid_bcc = item_s1.rx;
				res_d.crc     = 1'b1;
			end
			ACT_FOUND: begin
				res_d.uid_low    = st_low;
				res_d.uid_high   = st_high;
				res_d.uid_length = st_len;
				res_d.sak        = item_s1.rx[7:0];
				res_d.atqa       = atqa_q;
			end
			default: begin
			end
		endcase
	end

	// uid bytes collected over the cascade levels
	iaap_uid_store #(
		.MAX_UID_BYTES(MAX_UID_BYTES)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (uid_ctl),
		.src       (held_q),
		.uid_low   (st_low),
		.uid_high  (st_high),
		.uid_length(st_len)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			level_q     <= 2'd0;
			remaining_q <= 16'd0;
			atqa_q      <= 16'd0;
			held_q      <= 40'd0;
		end else begin
			phase_q     <= phase_d;
			level_q     <= level_d;
			remaining_q <= remaining_d;
			atqa_q      <= atqa_d;
			held_q      <= held_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {3'b000, res_q.atqa, res_q.sak, res_q.uid_length, res_q.uid_high,
		res_q.uid_low, res_q.crc, res_q.uid_bcc, res_q.nvb, res_q.sel};

`ifndef SYNTHESIS
	// a finished or timed out detection leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (res_q.action == ACT_FOUND || res_q.action == ACT_TIMEOUT))
		|-> (phase_q == PH_IDLE))
		else $error("done result without idle phase");

	// a pending command matches the phase that awaits its reply
	a_cmd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |->
		((res_q.action != ACT_WUPA || phase_q == PH_ATQA) &&
		 (res_q.action != ACT_ANTICOL || phase_q == PH_ANTICOL) &&
		 (res_q.action != ACT_SELECT || phase_q == PH_SAK)))
		else $error("pending command does not match phase");

	// a found card carries at least one full cascade level
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && res_q.action == ACT_FOUND)
		|-> (res_q.uid_length >= 4'd4 && res_q.uid_length <= UID_CNT_W'(MAX_UID_BYTES)))
		else $error("found uid length out of range");

	// an active detection always has time left
	a_time_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (remaining_q != 16'd0))
		else $error("active phase with no time left");

	// a stalled input item stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled item");
`endif

endmodule

// ===== dv/iso14443a_anticollision_poller_core_tb.sv =====
// self-checking testbench for the iso14443a anticollision poller core
module iso14443a_anticollision_poller_core_tb
	import iaap_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// one pending input item
	typedef struct packed {
		func_t       fn;
		logic [15:0] tmo;
		logic [3:0]  cnt;
		logic [39:0] rx;
	} poll_item_t;

	// one result item as the core reports it
	typedef struct packed {
		action_t     action;
		logic [7:0]  sel_cmd;
		logic [7:0]  nvb;
		logic [39:0] uid_bcc;
		logic        with_crc;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
		logic [3:0]  uid_length;
		logic [7:0]  sak;
		logic [15:0] atqa;
	} poll_result_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// rx_data[39:0], rx_count[43:40], deadline_ms[59:44], zero[63:60]
	logic [63:0]  s_tdata = '0;
	// func[1:0]
	logic [1:0]   s_tuser = FN_START;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// tx_select_cmd[7:0], tx_nvb[15:8], tx_uid_bcc[55:16], tx_with_crc[56],
	// uid_low[120:57], uid_high[136:121], uid_length[140:137], card_sak[148:141],
	// card_atqa[164:149], zero[167:165]
	logic [167:0] m_tdata;
	// action[2:0]
	logic [2:0]   m_tuser;

	poll_item_t   pending_items[$];
	poll_result_t expected_results[$];

	int send_idle_pct = 8;
	int recv_idle_pct = 71;
	int items_queued = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int cards_found = 0;
	int timeouts_seen = 0;
	int error_count = 0;

	// shadow state of the sequencer
	phase_t      ph = PH_IDLE;
	logic [1:0]  cl_level = '0;
	logic [15:0] ms_left = '0;
	logic [7:0]  uid_store [MAX_UID_BYTES_DEF] = '{default: 8'h00};
	logic [3:0]  uid_n = '0;
	logic [15:0] held_atqa = '0;
	logic [39:0] held_frame = '0;

	iso14443a_anticollision_poller_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("iso14443a_anticollision_poller_core_tb failed");
		$finish;
	end

	// advance the shadow sequencer by one item, return 1 when it yields a result
	function automatic bit predict_poll(input func_t fn, input logic [39:0] rx,
			input logic [3:0] cnt, input logic [15:0] tmo, output poll_result_t r);
		logic [7:0]  bcc;
		logic [63:0] lo;
		logic [15:0] hi;
		int          n_new;
		int          first;
		r = '0;
		// start reloads the deadline and drops any running detection
		if (fn == FN_START) begin
			ms_left = tmo;
			cl_level = '0;
			uid_n = '0;
			if (tmo == 16'd0) begin
				ph = PH_IDLE;
				r.action = ACT_TIMEOUT;
			end else begin
				ph = PH_ATQA;
				r.action = ACT_WUPA;
			end
			return 1'b1;
		end
		if (ph == PH_IDLE)
			return 1'b0;
		// tick counts down in every active phase
		if (fn == FN_TICK) begin
			if (ms_left != 16'd0)
				ms_left = ms_left - 16'd1;
			if (ms_left == 16'd0) begin
				ph = PH_IDLE;
				r.action = ACT_TIMEOUT;
				return 1'b1;
			end
			if (ph == PH_WAIT) begin
				ph = PH_ATQA;
				r.action = ACT_WUPA;
				return 1'b1;
			end
			return 1'b0;
		end
		if (ph == PH_WAIT)
			return 1'b0;
		// transfer failure: wait for a tick after wupa, else restart at once
		if (fn == FN_FAIL) begin
			if (ph == PH_ATQA) begin
				ph = PH_WAIT;
				return 1'b0;
			end
			ph = PH_ATQA;
			r.action = ACT_WUPA;
			return 1'b1;
		end
		// reply frame
		case (ph)
			PH_ATQA: begin
				if (cnt < 4'd2) begin
					ph = PH_WAIT;
					return 1'b0;
				end
				held_atqa = rx[15:0];
				cl_level = '0;
				uid_n = '0;
				ph = PH_ANTICOL;
				r.action = ACT_ANTICOL;
				r.sel_cmd = SEL_CL1 + {5'd0, cl_level, 1'b0};
				r.nvb = NVB_ANTICOL;
			end
			PH_ANTICOL: begin
				bcc = rx[7:0] ^ rx[15:8] ^ rx[23:16] ^ rx[31:24];
				if (cnt < 4'd5 || bcc != rx[39:32]) begin
					ph = PH_ATQA;
					r.action = ACT_WUPA;
				end else begin
					held_frame = rx;
					ph = PH_SAK;
					r.action = ACT_SELECT;
					r.sel_cmd = SEL_CL1 + {5'd0, cl_level, 1'b0};
					r.nvb = NVB_SELECT;
					r.uid_bcc = rx;
					r.with_crc = 1'b1;
				end
			end
			default: begin
				if (cnt < 4'd1) begin
					ph = PH_ATQA;
					r.action = ACT_WUPA;
					return 1'b1;
				end
				if (held_frame[7:0] == CASCADE_TAG) begin
					// cascade tag at the last level is invalid
					if (int'(cl_level) + 1 >= CASCADE_LEVELS_DEF) begin
						ph = PH_ATQA;
						r.action = ACT_WUPA;
						return 1'b1;
					end
					n_new = 3;
					first = 1;
				end else begin
					n_new = 4;
					first = 0;
				end
				// append uid bytes, saturating at the store size
				for (int i = 0; i < n_new; i++) begin
					if (uid_n < MAX_UID_BYTES_DEF) begin
						uid_store[uid_n] = held_frame[8*(first+i) +: 8];
						uid_n = uid_n + 4'd1;
					end
				end
				if (n_new == 3) begin
					cl_level = cl_level + 2'd1;
					ph = PH_ANTICOL;
					r.action = ACT_ANTICOL;
					r.sel_cmd = SEL_CL1 + {5'd0, cl_level, 1'b0};
					r.nvb = NVB_ANTICOL;
				end else begin
					lo = '0;
					hi = '0;
					for (int i = 0; i < MAX_UID_BYTES_DEF; i++) begin
						if (i < uid_n) begin
							if (i < 8)
								lo[8*i +: 8] = uid_store[i];
							else
								hi[8*(i-8) +: 8] = uid_store[i];
						end
					end
					ph = PH_IDLE;
					r.action = ACT_FOUND;
					r.uid_low = lo;
					r.uid_high = hi;
					r.uid_length = uid_n;
					r.sak = rx[7:0];
					r.atqa = held_atqa;
				end
			end
		endcase
		return 1'b1;
	endfunction

	function automatic logic [39:0] random_bytes();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// anticollision reply with a valid bcc, cascade tag on request
	function automatic logic [39:0] uid_frame(input bit with_tag);
		logic [31:0] uid;
		uid = $urandom;
		if (with_tag)
			uid[7:0] = CASCADE_TAG;
		else if (uid[7:0] == CASCADE_TAG)
			uid[0] = ~uid[0];
		return {uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ uid[31:24], uid};
	endfunction

	task automatic queue_item(input func_t fn, input logic [39:0] rx, input logic [3:0] cnt,
			input logic [15:0] tmo);
		pending_items.push_back('{fn: fn, tmo: tmo, cnt: cnt, rx: rx});
		items_queued++;
	endtask

	// occasional stray item inside a detection
	task automatic queue_noise();
		int pick;
		if ($urandom_range(99) < 12) begin
			pick = $urandom_range(99);
			if (pick < 50)
				queue_item(FN_TICK, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
			else if (pick < 70)
				queue_item(FN_FAIL, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
			else if (pick < 95)
				queue_item(FN_REPLY, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
			else
				queue_item(FN_START, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
		end
	endtask

	// one detection run: start, atqa, then one to four cascade levels
	task automatic queue_detection();
		logic [15:0] tmo;
		int          levels;
		case ($urandom_range(9))
			0: tmo = 16'($urandom_range(1, 6));
			1: tmo = 16'($urandom);
			default: tmo = 16'($urandom_range(40, 65535));
		endcase
		queue_item(FN_START, random_bytes(), 4'($urandom_range(8)), tmo);
		// failed wupa recovered by the next tick
		if ($urandom_range(4) == 0) begin
			if ($urandom_range(1) == 0)
				queue_item(FN_REPLY, random_bytes(), 4'($urandom_range(1)), 16'($urandom));
			else
				queue_item(FN_FAIL, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
			queue_item(FN_TICK, random_bytes(), 4'($urandom_range(8)), 16'($urandom));
		end
		queue_noise();
		queue_item(FN_REPLY, random_bytes(), 4'($urandom_range(2, 8)), 16'($urandom));
		levels = ($urandom_range(15) == 0) ? 4 : $urandom_range(1, 3);
		for (int i = 0; i < levels; i++) begin
			queue_noise();
			queue_item(FN_REPLY, uid_frame(i < levels - 1), 4'($urandom_range(5, 8)),
				16'($urandom));
			queue_noise();
			queue_item(FN_REPLY, random_bytes(), 4'($urandom_range(1, 8)), 16'($urandom));
		end
		queue_noise();
	endtask

	task automatic run_random(input int n);
		int start_count;
		start_count = items_queued;
		while (items_queued - start_count < n)
			queue_detection();
	endtask

	// wait until every item went in and every result came out
	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			error_count++;
		end
	endtask

	// driver: feeds pending items, predicts on every accepted item
	always @(posedge clk or negedge arst_n) begin : driver_proc
		poll_item_t   item;
		poll_result_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FN_START;
		end else begin
			if (s_tvalid && s_tready) begin
				items_accepted++;
				if (predict_poll(func_t'(s_tuser), s_tdata[39:0], s_tdata[43:40],
						s_tdata[59:44], res))
					expected_results.push_back(res);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'd0, item.tmo, item.cnt, item.rx};
					s_tuser <= item.fn;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor_proc
		poll_result_t exp_r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser == ACT_FOUND)
					cards_found++;
				if (m_tuser == ACT_TIMEOUT)
					timeouts_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result item, action %0d", m_tuser);
					error_count++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("action", 64'(exp_r.action), 64'(m_tuser));
					check_field("tx_select_cmd", 64'(exp_r.sel_cmd), 64'(m_tdata[7:0]));
					check_field("tx_nvb", 64'(exp_r.nvb), 64'(m_tdata[15:8]));
					check_field("tx_uid_bcc", 64'(exp_r.uid_bcc), 64'(m_tdata[55:16]));
					check_field("tx_with_crc", 64'(exp_r.with_crc), 64'(m_tdata[56]));
					check_field("uid_low", exp_r.uid_low, m_tdata[120:57]);
					check_field("uid_high", 64'(exp_r.uid_high), 64'(m_tdata[136:121]));
					check_field("uid_length", 64'(exp_r.uid_length), 64'(m_tdata[140:137]));
					check_field("card_sak", 64'(exp_r.sak), 64'(m_tdata[148:141]));
					check_field("card_atqa", 64'(exp_r.atqa), 64'(m_tdata[164:149]));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus: directed cases, then random runs under three idle patterns
	initial begin : stimulus
		logic [39:0] frame;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// idle phase ignores everything but start
		queue_item(FN_TICK, 40'hFF_FFFF_FFFF, 4'd8, 16'hFFFF);
		queue_item(FN_REPLY, 40'hFF_FFFF_FFFF, 4'd8, 16'hFFFF);
		// zero deadline times out at once
		queue_item(FN_START, 40'h0, 4'd0, 16'h0000);
		queue_item(FN_START, 40'h0, 4'd0, 16'hFFFF);
		// short atqa, then an ignored item while waiting, then the tick resends wupa
		queue_item(FN_REPLY, 40'hFF_FFFF_FFFF, 4'd1, 16'h0);
		queue_item(FN_REPLY, 40'hFF_FFFF_FFFF, 4'd8, 16'h0);
		queue_item(FN_TICK, 40'h0, 4'd0, 16'h0);
		// transfer failure after wupa
		queue_item(FN_FAIL, 40'h0, 4'd0, 16'h0);
		queue_item(FN_TICK, 40'h0, 4'd0, 16'h0);
		queue_item(FN_REPLY, 40'hFF_FFFF_FFFF, 4'd2, 16'h0);
		// bcc mismatch
		frame = uid_frame(1'b0) ^ 40'h01_0000_0000;
		queue_item(FN_REPLY, frame, 4'd5, 16'h0);
		queue_item(FN_REPLY, random_bytes(), 4'd8, 16'h0);
		// anticollision reply too short
		queue_item(FN_REPLY, uid_frame(1'b0), 4'd4, 16'h0);
		queue_item(FN_REPLY, random_bytes(), 4'd2, 16'h0);
		// cascade tag on every level, the last one is rejected
		for (int i = 0; i < 3; i++) begin
			queue_item(FN_REPLY, uid_frame(1'b1), 4'd8, 16'h0);
			queue_item(FN_REPLY, random_bytes(), 4'd1, 16'h0);
		end
		// failure after atqa restarts at once
		queue_item(FN_REPLY, random_bytes(), 4'd2, 16'h0);
		queue_item(FN_FAIL, 40'h0, 4'd0, 16'h0);
		// start while busy, then the deadline runs out
		queue_item(FN_START, 40'h0, 4'd0, 16'd2);
		queue_item(FN_TICK, 40'h0, 4'd0, 16'h0);
		queue_item(FN_TICK, 40'h0, 4'd0, 16'h0);

		run_random(520);
		drain();
		send_idle_pct = 71;
		recv_idle_pct = 8;
		run_random(515);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(515);
		drain();
		repeat (8) @(posedge clk);

		$display("run covered %0d input items and %0d result items", items_accepted,
			results_seen);
		$display("cards reported: %0d, deadlines expired: %0d", cards_found, timeouts_seen);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("iso14443a_anticollision_poller_core_tb passed");
		end else begin
			$display("iso14443a_anticollision_poller_core_tb failed");
		end
		$finish;
	end

endmodule
